@@ sv/gmm_pixel_posterior_estimator_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the mixture posterior estimator
// Implication checks on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef GMM_PIXEL_POSTERIOR_ESTIMATOR_MACROS_SVH
`define GMM_PIXEL_POSTERIOR_ESTIMATOR_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define GPP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gpp assertion failed");
// next-cycle implication
`define GPP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gpp assertion failed");
`else
`define GPP_ASSERT_IMPL(lbl, ante, cons)
`define GPP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ sv/gpp_pkg.sv @@
// ---------------------------------------------------------------------------
// gpp_pkg
// Shared sizes, opcodes, command struct and lookup tables of the estimator.
// ---------------------------------------------------------------------------
`default_nettype none

package gpp_pkg;

  localparam int MAX_COMPONENTS = 8;
  localparam int BANDS          = 4;
  localparam int WORDS          = BANDS + BANDS * BANDS + 1;
  localparam int TABLE_DEPTH    = MAX_COMPONENTS * WORDS;
  localparam int ADDR_W         = $clog2(TABLE_DEPTH);
  localparam int COMP_W         = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
  localparam int BAND_W         = (BANDS > 1) ? $clog2(BANDS) : 1;
  localparam int SUM_W          = 17 + $clog2(MAX_COMPONENTS);
  localparam int EXP_W          = $clog2(SUM_W);
  localparam int CONST_WORD     = WORDS - 1;

  localparam logic [16:0] LOG2E_Q16 = 17'd94548;
  localparam logic [15:0] LN2_Q16   = 16'd45426;

  // configuration register indexes
  localparam logic [1:0] CFG_COMPONENT_COUNT = 2'd0;
  localparam logic [1:0] CFG_BAND_COUNT      = 2'd1;
  localparam logic [1:0] CFG_INV_COV_SHIFT   = 2'd2;

  localparam logic [3:0] LABEL_NODATA = 4'b1111;

  // datapath operations
  typedef enum logic [4:0] {
    OP_IDLE, OP_LOAD, OP_CAPTURE, OP_READ, OP_DIFF, OP_INV_MUL, OP_ACC,
    OP_ROW, OP_ROW_MUL, OP_QUAD, OP_SCORE, OP_MAX, OP_EXP_T, OP_SUM,
    OP_POST, OP_LN_L2, OP_LN_NORM
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] addr;
    logic [COMP_W-1:0] comp;
    logic [BAND_W-1:0] band;
    logic              first;
    logic              use_lnorm;
    logic [5:0]        shift;
  } dp_cmd_t;

  // 2^(-i/16), Q16
  function automatic logic [16:0] exp2_tab(input logic [4:0] idx);
    logic [16:0] v;
    unique case (idx)
      5'd0:  v = 17'd65536;
      5'd1:  v = 17'd62757;
      5'd2:  v = 17'd60097;
      5'd3:  v = 17'd57549;
      5'd4:  v = 17'd55109;
      5'd5:  v = 17'd52773;
      5'd6:  v = 17'd50535;
      5'd7:  v = 17'd48393;
      5'd8:  v = 17'd46341;
      5'd9:  v = 17'd44376;
      5'd10: v = 17'd42495;
      5'd11: v = 17'd40693;
      5'd12: v = 17'd38968;
      5'd13: v = 17'd37316;
      5'd14: v = 17'd35734;
      5'd15: v = 17'd34219;
      5'd16: v = 17'd32768;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  // log2(1 + i/16), Q16
  function automatic logic [16:0] log2_tab(input logic [4:0] idx);
    logic [16:0] v;
    unique case (idx)
      5'd0:  v = 17'd0;
      5'd1:  v = 17'd5732;
      5'd2:  v = 17'd11136;
      5'd3:  v = 17'd16248;
      5'd4:  v = 17'd21098;
      5'd5:  v = 17'd25711;
      5'd6:  v = 17'd30109;
      5'd7:  v = 17'd34312;
      5'd8:  v = 17'd38336;
      5'd9:  v = 17'd42196;
      5'd10: v = 17'd45904;
      5'd11: v = 17'd49472;
      5'd12: v = 17'd52911;
      5'd13: v = 17'd56229;
      5'd14: v = 17'd59434;
      5'd15: v = 17'd62534;
      5'd16: v = 17'd65536;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

@@ sv/gpp_datapath.sv @@
// ---------------------------------------------------------------------------
// gpp_datapath
// Component table, shared multiplier, score/exp/log units and result regs.
// ---------------------------------------------------------------------------
`default_nettype none

module gpp_datapath (
  input  wire logic                    clk,
  input  wire gpp_pkg::dp_cmd_t        cmd,
  input  wire logic [2:0]              in_component,
  input  wire logic [4:0]              in_word_index,
  input  wire logic signed [31:0]      in_word_value,
  input  wire logic                    in_pixel_nodata,
  input  wire logic [15:0]             in_band_0,
  input  wire logic [15:0]             in_band_1,
  input  wire logic [15:0]             in_band_2,
  input  wire logic [15:0]             in_band_3,
  input  wire logic                    in_last_pixel,
  output logic [16:0]                  out_posterior,
  output logic signed [31:0]           out_log_lik,
  output logic signed [3:0]            out_best_label,
  output logic                         out_image_end
);

  localparam int LIN_W = gpp_pkg::EXP_W + 17;
  localparam int LPR_W = LIN_W + 16;

  // storage
  logic signed [31:0] mem_r [gpp_pkg::TABLE_DEPTH];
  logic signed [31:0] mem_q_r;
  logic [15:0]        band_r [gpp_pkg::BANDS];
  logic               nodata_r;
  logic               last_r;
  logic signed [31:0] diff_r [gpp_pkg::BANDS];
  logic signed [63:0] prod_r;
  logic signed [63:0] acc_r;
  logic signed [31:0] row_r;
  logic signed [63:0] quad_r;
  logic signed [31:0] score_r [gpp_pkg::MAX_COMPONENTS];
  logic signed [31:0] mx_r;
  logic [32:0]        t_r;
  logic [gpp_pkg::SUM_W-1:0] sum_r;
  logic [gpp_pkg::EXP_W-1:0] e_r;
  logic [16:0]        l2_r;
  logic signed [31:0] lnorm_r;
  logic [16:0]        post_r [gpp_pkg::MAX_COMPONENTS];
  logic [16:0]        best_val_r;
  logic [gpp_pkg::COMP_W-1:0] best_r;

  function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
    if (v > 65'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -65'sh0_8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return s[63:0];
  endfunction

  // table write address of a load word
  logic [gpp_pkg::ADDR_W-1:0] load_addr;
  logic                       load_ok;
  assign load_addr = gpp_pkg::ADDR_W'(gpp_pkg::ADDR_W'(in_component)
                     * gpp_pkg::ADDR_W'(gpp_pkg::WORDS)
                     + gpp_pkg::ADDR_W'(in_word_index));
  assign load_ok = (int'(in_component) < gpp_pkg::MAX_COMPONENTS)
                && (int'(in_word_index) < gpp_pkg::WORDS);

  // shared multiplier operands
  logic signed [31:0] diff_sel;
  logic signed [31:0] mul_a;
  assign diff_sel = diff_r[cmd.band];
  assign mul_a    = (cmd.op == gpp_pkg::OP_ROW_MUL) ? row_r : mem_q_r;

  // mean difference, row shift, score
  logic signed [33:0] diff34;
  logic signed [63:0] acc_sh;
  logic signed [64:0] score65;
  assign diff34  = $signed({10'd0, band_r[cmd.band], 8'd0}) - {{2{mem_q_r[31]}}, mem_q_r};
  assign acc_sh  = acc_r >>> cmd.shift;
  assign score65 = {{33{mem_q_r[31]}}, mem_q_r} - {quad_r[63], quad_r[63], quad_r[63:1]};

  // exp stage one: distance times log2(e)
  logic signed [31:0] exp_base;
  logic signed [32:0] d33;
  logic [31:0]        du;
  logic [48:0]        t49;
  assign exp_base = cmd.use_lnorm ? lnorm_r : mx_r;
  assign d33      = {exp_base[31], exp_base} - {score_r[cmd.comp][31], score_r[cmd.comp]};
  assign du       = d33[32] ? 32'd0 : d33[31:0];
  assign t49      = 49'(du) * 49'(gpp_pkg::LOG2E_Q16);

  // exp stage two: table, interpolation, integer shift
  logic [16:0] e_n;
  logic [3:0]  e_i;
  logic [11:0] e_rr;
  logic [16:0] e_lo;
  logic [16:0] e_hi;
  logic [28:0] e_pr;
  logic [16:0] e_v;
  logic [16:0] exp_val;
  assign e_n  = t_r[32:16];
  assign e_i  = t_r[15:12];
  assign e_rr = t_r[11:0];
  assign e_lo = gpp_pkg::exp2_tab({1'b0, e_i});
  assign e_hi = gpp_pkg::exp2_tab(5'({1'b0, e_i}) + 5'd1);
  assign e_pr = 29'(e_lo - e_hi) * 29'(e_rr);
  assign e_v  = e_lo - e_pr[28:12];
  assign exp_val = (e_n >= 17'd17) ? 17'd0 : (e_v >> e_n[4:0]);

  // log stage one: normalize sum, log2 of mantissa
  logic [gpp_pkg::EXP_W-1:0] l_p;
  logic [gpp_pkg::EXP_W-1:0] l_e;
  logic [gpp_pkg::SUM_W-1:0] l_m;
  logic [16:0] l_lo;
  logic [16:0] l_hi;
  logic [28:0] l_pr;
  logic [16:0] l_l2;
  always_comb begin
    l_p = '0;
    for (int b = 0; b < gpp_pkg::SUM_W; b++) begin
      if (sum_r[b]) l_p = gpp_pkg::EXP_W'(b);
    end
  end
  assign l_e  = (l_p > gpp_pkg::EXP_W'(16)) ? l_p - gpp_pkg::EXP_W'(16) : '0;
  assign l_m  = sum_r >> l_e;
  assign l_lo = gpp_pkg::log2_tab({1'b0, l_m[15:12]});
  assign l_hi = gpp_pkg::log2_tab(5'({1'b0, l_m[15:12]}) + 5'd1);
  assign l_pr = 29'(l_hi - l_lo) * 29'(l_m[11:0]);
  assign l_l2 = l_lo + l_pr[28:12];

  // log stage two: scale by ln 2, add max score
  logic [LIN_W-1:0]   lin;
  logic [LPR_W-1:0]   lprod;
  logic signed [64:0] lsum;
  assign lin   = {e_r, 16'd0} + LIN_W'(l2_r);
  assign lprod = LPR_W'(lin) * LPR_W'(gpp_pkg::LN2_Q16);
  assign lsum  = {{33{mx_r[31]}}, mx_r} + $signed(65'(lprod[LPR_W-1:16]));

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      gpp_pkg::OP_LOAD: begin
        if (load_ok) mem_r[load_addr] <= in_word_value;
      end
      gpp_pkg::OP_CAPTURE: begin
        nodata_r <= in_pixel_nodata;
        last_r   <= in_last_pixel;
        for (int j = 0; j < gpp_pkg::BANDS; j++) begin
          band_r[j] <= (j == 0) ? in_band_0 : (j == 1) ? in_band_1 :
                       (j == 2) ? in_band_2 : (j == 3) ? in_band_3 : 16'd0;
        end
      end
      gpp_pkg::OP_READ:    mem_q_r <= mem_r[cmd.addr];
      gpp_pkg::OP_DIFF:    diff_r[cmd.band] <= sat32(65'(diff34));
      gpp_pkg::OP_INV_MUL,
      gpp_pkg::OP_ROW_MUL: prod_r <= mul_a * diff_sel;
      gpp_pkg::OP_ACC:     acc_r  <= cmd.first ? prod_r : sat_add(acc_r, prod_r);
      gpp_pkg::OP_ROW:     row_r  <= sat32({acc_sh[63], acc_sh});
      gpp_pkg::OP_QUAD:    quad_r <= cmd.first ? prod_r : sat_add(quad_r, prod_r);
      gpp_pkg::OP_SCORE:   score_r[cmd.comp] <= sat32(score65);
      gpp_pkg::OP_MAX: begin
        if (cmd.first || score_r[cmd.comp] > mx_r) mx_r <= score_r[cmd.comp];
      end
      gpp_pkg::OP_EXP_T:   t_r <= t49[48:16];
      gpp_pkg::OP_SUM: begin
        sum_r <= cmd.first ? gpp_pkg::SUM_W'(exp_val)
                           : sum_r + gpp_pkg::SUM_W'(exp_val);
      end
      gpp_pkg::OP_POST: begin
        post_r[cmd.comp] <= exp_val;
        if (cmd.first || exp_val > best_val_r) begin
          best_val_r <= exp_val;
          best_r     <= cmd.comp;
        end
      end
      gpp_pkg::OP_LN_L2: begin
        e_r  <= l_e;
        l2_r <= l_l2;
      end
      gpp_pkg::OP_LN_NORM: lnorm_r <= sat32(lsum);
      default: ;
    endcase
  end

  // result payload
  assign out_posterior  = nodata_r ? 17'd0 : post_r[cmd.comp];
  assign out_log_lik    = nodata_r ? 32'sd0 : lnorm_r;
  assign out_best_label = nodata_r ? gpp_pkg::LABEL_NODATA : 4'(best_r);
  assign out_image_end  = last_r;

endmodule

`default_nettype wire

@@ sv/gpp_controller.sv @@
// ---------------------------------------------------------------------------
// gpp_controller
// Configuration registers, handshakes and the per-pixel operation sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

`include "gmm_pixel_posterior_estimator_macros.svh"

module gpp_controller (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [5:0]         cfg_wdata,
  input  wire logic               in_valid,
  input  wire logic               in_kind,
  input  wire logic               in_pixel_nodata,
  output logic                    in_stall,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [2:0]              out_result_component,
  output logic                    out_last_of_run,
  output gpp_pkg::dp_cmd_t        cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_MEAN_RD, S_MEAN_DIFF, S_INV_RD, S_INV_MUL, S_INV_ACC, S_ROW,
    S_ROW_MUL, S_QUAD, S_CONST_RD, S_SCORE, S_MAX, S_SUM_T, S_SUM_ACC,
    S_LN_L2, S_LN_NORM, S_POST_T, S_POST_WR, S_EMIT
  } state_t;

  state_t                     state_r;
  logic [gpp_pkg::COMP_W-1:0] c_r;
  logic [gpp_pkg::BAND_W-1:0] i_r;
  logic [gpp_pkg::BAND_W-1:0] j_r;
  logic [3:0]                 comp_count_r;
  logic [2:0]                 band_count_r;
  logic [5:0]                 shift_r;

  // active counts, clamped into range, as last index
  logic [gpp_pkg::COMP_W-1:0] kmax;
  logic [gpp_pkg::BAND_W-1:0] nbmax;
  always_comb begin
    if (comp_count_r == 4'd0) kmax = '0;
    else if (int'(comp_count_r) > gpp_pkg::MAX_COMPONENTS)
      kmax = gpp_pkg::COMP_W'(gpp_pkg::MAX_COMPONENTS - 1);
    else kmax = gpp_pkg::COMP_W'(comp_count_r - 4'd1);
    if (band_count_r == 3'd0) nbmax = '0;
    else if (int'(band_count_r) > gpp_pkg::BANDS)
      nbmax = gpp_pkg::BAND_W'(gpp_pkg::BANDS - 1);
    else nbmax = gpp_pkg::BAND_W'(band_count_r - 3'd1);
  end

  // table addresses
  logic [gpp_pkg::ADDR_W-1:0] base_addr;
  logic [gpp_pkg::ADDR_W-1:0] inv_addr;
  assign base_addr = gpp_pkg::ADDR_W'(gpp_pkg::ADDR_W'(c_r) * gpp_pkg::ADDR_W'(gpp_pkg::WORDS));
  assign inv_addr  = base_addr + gpp_pkg::ADDR_W'(gpp_pkg::BANDS)
                   + gpp_pkg::ADDR_W'(gpp_pkg::ADDR_W'(i_r)
                     * (gpp_pkg::ADDR_W'(nbmax) + gpp_pkg::ADDR_W'(1)))
                   + gpp_pkg::ADDR_W'(j_r);

  assign in_stall             = (state_r != S_IDLE);
  assign out_valid            = (state_r == S_EMIT);
  assign out_result_component = 3'(c_r);
  assign out_last_of_run      = (c_r == kmax);

  // command decode
  always_comb begin
    cmd           = '0;
    cmd.op        = gpp_pkg::OP_IDLE;
    cmd.comp      = c_r;
    cmd.band      = j_r;
    cmd.shift     = shift_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) cmd.op = in_kind ? gpp_pkg::OP_CAPTURE : gpp_pkg::OP_LOAD;
      end
      S_MEAN_RD: begin
        cmd.op   = gpp_pkg::OP_READ;
        cmd.addr = base_addr + gpp_pkg::ADDR_W'(j_r);
      end
      S_MEAN_DIFF: cmd.op = gpp_pkg::OP_DIFF;
      S_INV_RD: begin
        cmd.op   = gpp_pkg::OP_READ;
        cmd.addr = inv_addr;
      end
      S_INV_MUL: cmd.op = gpp_pkg::OP_INV_MUL;
      S_INV_ACC: begin
        cmd.op    = gpp_pkg::OP_ACC;
        cmd.first = (j_r == '0);
      end
      S_ROW: cmd.op = gpp_pkg::OP_ROW;
      S_ROW_MUL: begin
        cmd.op   = gpp_pkg::OP_ROW_MUL;
        cmd.band = i_r;
      end
      S_QUAD: begin
        cmd.op    = gpp_pkg::OP_QUAD;
        cmd.first = (i_r == '0);
      end
      S_CONST_RD: begin
        cmd.op   = gpp_pkg::OP_READ;
        cmd.addr = base_addr + gpp_pkg::ADDR_W'(gpp_pkg::CONST_WORD);
      end
      S_SCORE: cmd.op = gpp_pkg::OP_SCORE;
      S_MAX: begin
        cmd.op    = gpp_pkg::OP_MAX;
        cmd.first = (c_r == '0);
      end
      S_SUM_T: cmd.op = gpp_pkg::OP_EXP_T;
      S_SUM_ACC: begin
        cmd.op    = gpp_pkg::OP_SUM;
        cmd.first = (c_r == '0);
      end
      S_LN_L2:   cmd.op = gpp_pkg::OP_LN_L2;
      S_LN_NORM: cmd.op = gpp_pkg::OP_LN_NORM;
      S_POST_T: begin
        cmd.op        = gpp_pkg::OP_EXP_T;
        cmd.use_lnorm = 1'b1;
      end
      S_POST_WR: begin
        cmd.op    = gpp_pkg::OP_POST;
        cmd.first = (c_r == '0);
      end
      S_EMIT: cmd.op = gpp_pkg::OP_IDLE;
      default: cmd.op = gpp_pkg::OP_IDLE;
    endcase
  end

  // state, counters and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      c_r          <= '0;
      i_r          <= '0;
      j_r          <= '0;
      comp_count_r <= 4'd1;
      band_count_r <= 3'd4;
      shift_r      <= 6'd32;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          gpp_pkg::CFG_COMPONENT_COUNT: comp_count_r <= cfg_wdata[3:0];
          gpp_pkg::CFG_BAND_COUNT:      band_count_r <= cfg_wdata[2:0];
          gpp_pkg::CFG_INV_COV_SHIFT:   shift_r      <= cfg_wdata;
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && in_kind) begin
            c_r     <= '0;
            j_r     <= '0;
            state_r <= in_pixel_nodata ? S_EMIT : S_MEAN_RD;
          end
        end
        S_MEAN_RD: state_r <= S_MEAN_DIFF;
        S_MEAN_DIFF: begin
          if (j_r == nbmax) begin
            i_r     <= '0;
            j_r     <= '0;
            state_r <= S_INV_RD;
          end else begin
            j_r     <= j_r + 1'b1;
            state_r <= S_MEAN_RD;
          end
        end
        S_INV_RD:  state_r <= S_INV_MUL;
        S_INV_MUL: state_r <= S_INV_ACC;
        S_INV_ACC: begin
          if (j_r == nbmax) state_r <= S_ROW;
          else begin
            j_r     <= j_r + 1'b1;
            state_r <= S_INV_RD;
          end
        end
        S_ROW:     state_r <= S_ROW_MUL;
        S_ROW_MUL: state_r <= S_QUAD;
        S_QUAD: begin
          j_r <= '0;
          if (i_r == nbmax) state_r <= S_CONST_RD;
          else begin
            i_r     <= i_r + 1'b1;
            state_r <= S_INV_RD;
          end
        end
        S_CONST_RD: state_r <= S_SCORE;
        S_SCORE: begin
          j_r <= '0;
          if (c_r == kmax) begin
            c_r     <= '0;
            state_r <= S_MAX;
          end else begin
            c_r     <= c_r + 1'b1;
            state_r <= S_MEAN_RD;
          end
        end
        S_MAX: begin
          if (c_r == kmax) begin
            c_r     <= '0;
            state_r <= S_SUM_T;
          end else c_r <= c_r + 1'b1;
        end
        S_SUM_T: state_r <= S_SUM_ACC;
        S_SUM_ACC: begin
          if (c_r == kmax) begin
            c_r     <= '0;
            state_r <= S_LN_L2;
          end else begin
            c_r     <= c_r + 1'b1;
            state_r <= S_SUM_T;
          end
        end
        S_LN_L2:   state_r <= S_LN_NORM;
        S_LN_NORM: state_r <= S_POST_T;
        S_POST_T:  state_r <= S_POST_WR;
        S_POST_WR: begin
          if (c_r == kmax) begin
            c_r     <= '0;
            state_r <= S_EMIT;
          end else begin
            c_r     <= c_r + 1'b1;
            state_r <= S_POST_T;
          end
        end
        S_EMIT: begin
          if (!out_stall) begin
            if (c_r == kmax) state_r <= S_IDLE;
            else c_r <= c_r + 1'b1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `GPP_ASSERT_NEXT(a_emit_done_idle, state_r == S_EMIT && !out_stall && c_r == kmax, state_r == S_IDLE)
  `GPP_ASSERT_NEXT(a_pixel_busy, in_valid && !in_stall && in_kind, in_stall)
  `GPP_ASSERT_IMPL(a_comp_range, state_r != S_IDLE, c_r <= kmax)

endmodule

`default_nettype wire

@@ sv/gmm_pixel_posterior_estimator.sv @@
// ---------------------------------------------------------------------------
// gmm_pixel_posterior_estimator
// Gaussian mixture E-step: per-pixel component posteriors, log-likelihood
// and arg-max label from a loaded per-component parameter table.
// ---------------------------------------------------------------------------
// A load word (kind 0) is taken without stalling the input. A pixel with k
// active components and nb active bands occupies the block from its
// accepting cycle until its last result word is taken; it ends with its
// result words, one per component, held while the receiver stalls; a
// nodata pixel goes straight to its k result words. The occupancy is set
// by the single shared 32x32 multiplier and the single read port of the
// parameter table, each used one operation at a time, and one item is in
// flight at once.
`default_nettype none

module gmm_pixel_posterior_estimator (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [5:0]         cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_kind,
  input  wire logic [2:0]         in_component,
  input  wire logic [4:0]         in_word_index,
  input  wire logic signed [31:0] in_word_value,
  input  wire logic               in_pixel_nodata,
  input  wire logic [15:0]        in_band_0,
  input  wire logic [15:0]        in_band_1,
  input  wire logic [15:0]        in_band_2,
  input  wire logic [15:0]        in_band_3,
  input  wire logic               in_last_pixel,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [2:0]              out_result_component,
  output logic [16:0]             out_posterior,
  output logic signed [31:0]      out_log_lik,
  output logic signed [3:0]       out_best_label,
  output logic                    out_last_of_run,
  output logic                    out_image_end
);

  gpp_pkg::dp_cmd_t cmd;

  gpp_controller u_ctrl (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_kind              (in_kind),
    .in_pixel_nodata      (in_pixel_nodata),
    .in_stall             (in_stall),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_result_component (out_result_component),
    .out_last_of_run      (out_last_of_run),
    .cmd                  (cmd)
  );

  gpp_datapath u_dp (
    .clk             (clk),
    .cmd             (cmd),
    .in_component    (in_component),
    .in_word_index   (in_word_index),
    .in_word_value   (in_word_value),
    .in_pixel_nodata (in_pixel_nodata),
    .in_band_0       (in_band_0),
    .in_band_1       (in_band_1),
    .in_band_2       (in_band_2),
    .in_band_3       (in_band_3),
    .in_last_pixel   (in_last_pixel),
    .out_posterior   (out_posterior),
    .out_log_lik     (out_log_lik),
    .out_best_label  (out_best_label),
    .out_image_end   (out_image_end)
  );

endmodule

`default_nettype wire
